@@ rtl/gr2r_pkg.sv @@
// ----------------------------------------------------------------------------
// gr2r_pkg
// Shared types, constants and helper functions for the glyph row rasteriser.
// ----------------------------------------------------------------------------
package gr2r_pkg;

    // Geometry of one glyph row.
    localparam int unsigned COLS    = 8;
    localparam int unsigned COL_W   = $clog2(COLS);
    localparam int unsigned COORD_W = 16;

    // Rows beyond this count are never drawn, whatever the height register says.
    localparam logic [4:0] MAX_GLYPH_ROWS = 5'd16;

    // Pixel mask of the leftmost column (bit 7 is column 0).
    localparam logic [COLS-1:0] LEFT_COLUMN_MASK = 8'h80;

    // Default depth of the queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PIXEL_SCALE  = 2'd2;
    localparam logic [1:0] REG_INK_COLOR    = 2'd3;

    // Register reset values.
    localparam logic [3:0]  GLYPH_WIDTH_RST  = 4'd8;
    localparam logic [4:0]  GLYPH_HEIGHT_RST = 5'd8;
    localparam logic [7:0]  PIXEL_SCALE_RST  = 8'd1;
    localparam logic [15:0] INK_COLOR_RST    = 16'hFFFF;

    // One input beat: a single glyph row.
    typedef struct packed {
        logic [7:0]  row_bits;
        logic [3:0]  row_index;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
    } gr2r_in_t;

    // One result beat: a filled square.
    typedef struct packed {
        logic [15:0] rect_left;
        logic [15:0] rect_top;
        logic [15:0] rect_right;
        logic [15:0] rect_bottom;
        logic [15:0] rect_color;
        logic        last_rect;
    } gr2r_out_t;

    // Configuration as seen by the front and the back.
    typedef struct packed {
        logic [3:0]  glyph_width;
        logic [4:0]  glyph_height;
        logic [7:0]  pixel_scale;
        logic [15:0] ink_color;
    } gr2r_cfg_t;

    // A classified row waiting for the back: only drawable columns remain set.
    typedef struct packed {
        logic [7:0]  bits;
        logic [15:0] origin_x;
        logic [15:0] top;
    } gr2r_job_t;

    // Columns that lie inside the configured glyph width; widths above 8 act as 8.
    function automatic logic [COLS-1:0] col_mask(input logic [3:0] width);
        logic [COLS-1:0] mask;
        if (width >= 4'(COLS))
            mask = '1;
        else
            mask = ~({COLS{1'b1}} >> width);
        return mask;
    endfunction

    // A scale of zero draws as a scale of one.
    function automatic logic [7:0] eff_scale(input logic [7:0] scale);
        logic [7:0] s;
        s = (scale == 8'd0) ? 8'd1 : scale;
        return s;
    endfunction

endpackage

@@ rtl/gr2r_front.sv @@
// ----------------------------------------------------------------------------
// gr2r_front
// Accepts glyph rows, drops those that draw nothing and works out the row's
// top coordinate before handing it to the job queue.
// ----------------------------------------------------------------------------
module gr2r_front (
    input  logic                push,
    input  logic                full,
    input  gr2r_pkg::gr2r_in_t  row_in,
    input  gr2r_pkg::gr2r_cfg_t cfg,
    output logic                job_push,
    output gr2r_pkg::gr2r_job_t job
);
    import gr2r_pkg::*;

    logic [7:0]  masked_bits;
    logic [7:0]  scale;
    logic [11:0] row_offset;
    logic        row_inside;

    // Keep only the columns inside the glyph width.
    assign masked_bits = row_in.row_bits & col_mask(cfg.glyph_width);
    assign scale       = eff_scale(cfg.pixel_scale);

    // A row draws only if it lies inside both the configured and the absolute height.
    assign row_inside = ({1'b0, row_in.row_index} < cfg.glyph_height) &&
                        ({1'b0, row_in.row_index} < MAX_GLYPH_ROWS);

    // Vertical position of the row: origin plus row times scale, wrapping.
    assign row_offset = 12'(row_in.row_index) * 12'(scale);

    assign job.bits     = masked_bits;
    assign job.origin_x = row_in.origin_x;
    assign job.top      = row_in.origin_y + 16'(row_offset);

    // Only rows with at least one square to draw are queued.
    assign job_push = push && !full && row_inside && (masked_bits != 8'd0);

endmodule

@@ rtl/gr2r_queue.sv @@
// ----------------------------------------------------------------------------
// gr2r_queue
// Short first-in first-out queue of classified rows between front and back.
// ----------------------------------------------------------------------------
module gr2r_queue #(
    parameter int unsigned DEPTH = gr2r_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  gr2r_pkg::gr2r_job_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output gr2r_pkg::gr2r_job_t rd_data,
    output logic                empty
);
    import gr2r_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    gr2r_job_t        slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    // Pointer and fill count update, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Row storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/gr2r_back.sv @@
// ----------------------------------------------------------------------------
// gr2r_back
// Walks the set columns of the current row left to right, one square per
// cycle into an output register while that register is free or being emptied.
// ----------------------------------------------------------------------------
module gr2r_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    input  gr2r_pkg::gr2r_job_t job,
    output logic                job_pop,
    input  gr2r_pkg::gr2r_cfg_t cfg,
    output logic                empty,
    input  logic                pop,
    output gr2r_pkg::gr2r_out_t rect_out
);
    import gr2r_pkg::*;

    logic             cur_valid_reg, cur_valid_next;
    logic [COLS-1:0]  cur_bits_reg, cur_bits_next;
    logic [15:0]      cur_ox_reg, cur_ox_next;
    logic [15:0]      cur_top_reg, cur_top_next;
    logic             out_valid_reg, out_valid_next;
    gr2r_out_t        out_data_reg;

    logic             out_ready;
    logic             emit;
    logic             row_done;
    logic [COL_W-1:0] col;
    logic [COLS-1:0]  rest_bits;
    logic [7:0]       scale;
    logic [10:0]      col_offset;
    logic [15:0]      left;
    gr2r_out_t        rect;

    // Leftmost set column of the remaining row bits.
    always_comb
    begin
        col = '0;
        for (int i = COLS - 1; i >= 0; i--)
        begin
            if (cur_bits_reg[COLS - 1 - i])
            begin
                col = COL_W'(i);
            end
        end
    end

    assign scale      = eff_scale(cfg.pixel_scale);
    assign rest_bits  = cur_bits_reg & ~(LEFT_COLUMN_MASK >> col);
    assign col_offset = 11'(col) * 11'(scale);
    assign left       = cur_ox_reg + 16'(col_offset);

    // The square for the current column.
    assign rect.rect_left   = left;
    assign rect.rect_top    = cur_top_reg;
    assign rect.rect_right  = left + 16'(scale) - 16'd1;
    assign rect.rect_bottom = cur_top_reg + 16'(scale) - 16'd1;
    assign rect.rect_color  = cfg.ink_color;
    assign rect.last_rect   = (rest_bits == '0);

    // A square moves on when the output register is free or being emptied.
    assign out_ready = !out_valid_reg || pop;
    assign emit      = cur_valid_reg && out_ready;
    assign row_done  = emit && (rest_bits == '0);
    assign job_pop   = !job_empty && (!cur_valid_reg || row_done);

    // Current row: consume one column per square, load the next row on finishing.
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_bits_next  = cur_bits_reg;
        cur_ox_next    = cur_ox_reg;
        cur_top_next   = cur_top_reg;
        if (emit)
        begin
            cur_bits_next = rest_bits;
            if (rest_bits == '0)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (job_pop)
        begin
            cur_valid_next = 1'b1;
            cur_bits_next  = job.bits;
            cur_ox_next    = job.origin_x;
            cur_top_next   = job.top;
        end
    end

    // Output register occupancy.
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cur_bits_reg <= cur_bits_next;
        cur_ox_reg   <= cur_ox_next;
        cur_top_reg  <= cur_top_next;
        if (emit)
        begin
            out_data_reg <= rect;
        end
    end

    assign empty    = !out_valid_reg;
    assign rect_out = out_data_reg;

endmodule

@@ rtl/glyph_row_to_scaled_rects.sv @@
// ----------------------------------------------------------------------------
// glyph_row_to_scaled_rects
// Turns rows of a 1-bit bitmap glyph into filled-square drawing commands.
// ----------------------------------------------------------------------------
// A row beat is taken whenever the row queue has room, and a row that draws
// nothing (blank, or outside the glyph height) is dropped without entering the
// queue. A drawn row with n set columns inside the glyph width yields n squares,
// one per cycle from the back end's column walker while the output register can
// take them; the output register lets one square be taken every cycle. Up to
// QUEUE_DEPTH classified rows wait between the two halves.
// Configuration should be written only while no row is in flight.
module glyph_row_to_scaled_rects #(
    parameter int unsigned QUEUE_DEPTH = gr2r_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // Row input
    input  logic                push,
    output logic                full,
    input  gr2r_pkg::gr2r_in_t  row_in,
    // Square output
    output logic                empty,
    input  logic                pop,
    output gr2r_pkg::gr2r_out_t rect_out,
    // Configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import gr2r_pkg::*;

    logic [3:0]  glyph_width_reg;
    logic [4:0]  glyph_height_reg;
    logic [7:0]  pixel_scale_reg;
    logic [15:0] ink_color_reg;
    logic        cfg_write;
    logic [1:0]  reg_index;
    gr2r_cfg_t   cfg;
    logic        job_push;
    gr2r_job_t   job_in;
    gr2r_job_t   job_out;
    logic        job_empty;
    logic        job_pop;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_width_reg  <= GLYPH_WIDTH_RST;
            glyph_height_reg <= GLYPH_HEIGHT_RST;
            pixel_scale_reg  <= PIXEL_SCALE_RST;
            ink_color_reg    <= INK_COLOR_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_GLYPH_WIDTH:  glyph_width_reg  <= pwdata[3:0];
                REG_GLYPH_HEIGHT: glyph_height_reg <= pwdata[4:0];
                REG_PIXEL_SCALE:  pixel_scale_reg  <= pwdata[7:0];
                REG_INK_COLOR:    ink_color_reg    <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_index)
            REG_GLYPH_WIDTH:  prdata = 32'(glyph_width_reg);
            REG_GLYPH_HEIGHT: prdata = 32'(glyph_height_reg);
            REG_PIXEL_SCALE:  prdata = 32'(pixel_scale_reg);
            REG_INK_COLOR:    prdata = 32'(ink_color_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.glyph_width  = glyph_width_reg;
    assign cfg.glyph_height = glyph_height_reg;
    assign cfg.pixel_scale  = pixel_scale_reg;
    assign cfg.ink_color    = ink_color_reg;

    gr2r_front u_front (
        .push     (push),
        .full     (full),
        .row_in   (row_in),
        .cfg      (cfg),
        .job_push (job_push),
        .job      (job_in)
    );

    gr2r_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (full),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .empty   (job_empty)
    );

    gr2r_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .cfg       (cfg),
        .empty     (empty),
        .pop       (pop),
        .rect_out  (rect_out)
    );

endmodule

@@ rtl/gr2r_checker.sv @@
// ----------------------------------------------------------------------------
// gr2r_checker
// Port-level checks for the glyph row rasteriser, bound to the top level.
// ----------------------------------------------------------------------------
module gr2r_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input gr2r_pkg::gr2r_out_t rect_out
);

    // Nothing is waiting on the output straight after reset.
    a_empty_after_reset: assert property (
        @(posedge clk) $past(!rst_n) |-> empty
    ) else $error("result queue not empty after reset");

    // A waiting beat that is not taken stays, unchanged.
    a_stall_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rect_out))
    ) else $error("waiting square changed or vanished");

    // Every rectangle is a square.
    a_square: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty |-> (16'(rect_out.rect_right - rect_out.rect_left) ==
                    16'(rect_out.rect_bottom - rect_out.rect_top))
    ) else $error("rectangle is not a square");

endmodule

bind glyph_row_to_scaled_rects gr2r_checker u_gr2r_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .rect_out (rect_out)
);
